// ===== hw/rtl/cord_pkg.sv =====
// cord_pkg: shared constants, stage record and arctangent table for the
// sine/cosine rotation pipeline. No dependencies.
`default_nettype none

package cord_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int NUM_CELLS    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  localparam int TURN_W = 32;
  localparam int XY_W   = 33;
  localparam int Z_W    = 33;
  localparam int SH_W   = $clog2(ATAN_ENTRIES);
  localparam int OUT_W  = 16;
  localparam int RND_W  = XY_W - 15;

  localparam logic signed [XY_W-1:0]  GAIN_Q30  = XY_W'(652032874);
  localparam logic signed [XY_W-1:0]  AXIS_ONE  = XY_W'(64'sd16384 <<< 16);
  localparam logic signed [OUT_W-1:0] ONE_Q14   = OUT_W'(16384);
  localparam logic signed [XY_W:0]    HALF_LSB  = (XY_W+1)'(32768);

  typedef struct packed {
    logic                   vld;
    logic                   axis;
    logic [1:0]             quad;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } stage_t;

  function automatic logic [TURN_W-1:0] atan_turn(input logic [SH_W-1:0] idx);
    logic [TURN_W-1:0] v;
    case (idx)
      SH_W'(0):  v = 32'h20000000;
      SH_W'(1):  v = 32'h12E4051E;
      SH_W'(2):  v = 32'h09FB385B;
      SH_W'(3):  v = 32'h051111D4;
      SH_W'(4):  v = 32'h028B0D43;
      SH_W'(5):  v = 32'h0145D7E1;
      SH_W'(6):  v = 32'h00A2F61E;
      SH_W'(7):  v = 32'h00517C55;
      SH_W'(8):  v = 32'h0028BE53;
      SH_W'(9):  v = 32'h00145F2F;
      SH_W'(10): v = 32'h000A2F98;
      SH_W'(11): v = 32'h000517CC;
      SH_W'(12): v = 32'h00028BE6;
      SH_W'(13): v = 32'h000145F3;
      SH_W'(14): v = 32'h0000A2FA;
      SH_W'(15): v = 32'h0000517D;
      SH_W'(16): v = 32'h000028BE;
      SH_W'(17): v = 32'h0000145F;
      SH_W'(18): v = 32'h00000A30;
      SH_W'(19): v = 32'h00000518;
      SH_W'(20): v = 32'h0000028C;
      SH_W'(21): v = 32'h00000146;
      SH_W'(22): v = 32'h000000A3;
      SH_W'(23): v = 32'h00000051;
      default:   v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cord_if.sv =====
// cord_in_if / cord_out_if: valid/ready channels for angle beats and
// direction beats. Depends on cord_pkg.
`default_nettype none

interface cord_in_if;
  logic                            valid;
  logic                            ready;
  logic [cord_pkg::ANGLE_BITS-1:0] angle;
  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface cord_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [cord_pkg::OUT_W-1:0] dir_x;
  logic signed [cord_pkg::OUT_W-1:0] dir_z;
  modport source (output valid, output dir_x, output dir_z, input ready);
  modport sink   (input valid, input dir_x, input dir_z, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cord_prep.sv =====
// cord_prep: folds the heading into a quadrant and a residual within one
// eighth of a turn, and seeds the rotation. Depends on cord_pkg.
`default_nettype none

module cord_prep (
  input  wire logic                            vld,
  input  wire logic [cord_pkg::ANGLE_BITS-1:0] angle,
  output cord_pkg::stage_t                     d_o
);

  logic [cord_pkg::TURN_W-1:0] turn;
  logic [cord_pkg::TURN_W-3:0] resid;

  always_comb begin
    turn  = {angle, {(cord_pkg::TURN_W - cord_pkg::ANGLE_BITS){1'b0}}};
    resid = turn[cord_pkg::TURN_W-3:0];
    d_o.vld  = vld;
    d_o.axis = (resid == '0);
    d_o.x    = cord_pkg::GAIN_Q30;
    d_o.y    = '0;
    if (resid[cord_pkg::TURN_W-3]) begin
      // residual past an eighth: take it from the next quadrant
      d_o.quad = turn[cord_pkg::TURN_W-1 -: 2] + 2'd1;
      d_o.z    = {{(cord_pkg::Z_W - cord_pkg::TURN_W + 2){1'b1}}, resid};
    end else begin
      d_o.quad = turn[cord_pkg::TURN_W-1 -: 2];
      d_o.z    = {{(cord_pkg::Z_W - cord_pkg::TURN_W + 2){1'b0}}, resid};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cord_cell.sv =====
// cord_cell: one registered micro-rotation of the chain.
// Depends on cord_pkg.
`default_nettype none

module cord_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic [cord_pkg::SH_W-1:0]     sh,
  input  wire logic [cord_pkg::TURN_W-1:0]   atan,
  input  cord_pkg::stage_t                   d_i,
  output cord_pkg::stage_t                   d_o
);

  logic                              vld_r;
  cord_pkg::stage_t                  data_r;
  cord_pkg::stage_t                  data_nxt;
  logic signed [cord_pkg::XY_W-1:0]  dx;
  logic signed [cord_pkg::XY_W-1:0]  dy;
  logic signed [cord_pkg::Z_W-1:0]   da;

  always_comb begin
    dx = d_i.y >>> sh;
    dy = d_i.x >>> sh;
    da = {{(cord_pkg::Z_W - cord_pkg::TURN_W){1'b0}}, atan};
    data_nxt = d_i;
    if (!d_i.z[cord_pkg::Z_W-1]) begin
      data_nxt.x = d_i.x - dx;
      data_nxt.y = d_i.y + dy;
      data_nxt.z = d_i.z - da;
    end else begin
      data_nxt.x = d_i.x + dx;
      data_nxt.y = d_i.y - dy;
      data_nxt.z = d_i.z + da;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  always_comb begin
    d_o     = data_r;
    d_o.vld = vld_r;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cord_post.sv =====
// cord_post: quadrant swap and sign fix, rounding to Q1.14 with saturation,
// and the output register. Depends on cord_pkg.
`default_nettype none

module cord_post (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               en,
  input  cord_pkg::stage_t                        d_i,
  output logic                                    vld,
  output logic signed [cord_pkg::OUT_W-1:0]       dir_x,
  output logic signed [cord_pkg::OUT_W-1:0]       dir_z
);

  logic                              vld_r;
  logic signed [cord_pkg::OUT_W-1:0] dir_x_r;
  logic signed [cord_pkg::OUT_W-1:0] dir_z_r;
  logic signed [cord_pkg::OUT_W-1:0] dir_x_nxt;
  logic signed [cord_pkg::OUT_W-1:0] dir_z_nxt;
  logic signed [cord_pkg::XY_W-1:0]  c;
  logic signed [cord_pkg::XY_W-1:0]  s;
  logic signed [cord_pkg::XY_W-1:0]  ox;
  logic signed [cord_pkg::XY_W-1:0]  oz;

  function automatic logic signed [cord_pkg::OUT_W-1:0] to_q14(
    input logic signed [cord_pkg::XY_W-1:0] v
  );
    logic signed [cord_pkg::XY_W:0]    sum;
    logic signed [cord_pkg::RND_W-1:0] r;
    logic signed [cord_pkg::OUT_W-1:0] q;
    sum = {v[cord_pkg::XY_W-1], v} + cord_pkg::HALF_LSB;
    r   = sum[cord_pkg::XY_W:16];
    if (r > cord_pkg::RND_W'(cord_pkg::ONE_Q14)) begin
      q = cord_pkg::ONE_Q14;
    end else if (r < -cord_pkg::RND_W'(cord_pkg::ONE_Q14)) begin
      q = -cord_pkg::ONE_Q14;
    end else begin
      q = r[cord_pkg::OUT_W-1:0];
    end
    return q;
  endfunction

  always_comb begin
    c = d_i.axis ? cord_pkg::AXIS_ONE : d_i.x;
    s = d_i.axis ? '0 : d_i.y;
    case (d_i.quad)
      2'd0: begin
        ox = c;
        oz = s;
      end
      2'd1: begin
        ox = -s;
        oz = c;
      end
      2'd2: begin
        ox = -c;
        oz = -s;
      end
      default: begin
        ox = s;
        oz = -c;
      end
    endcase
    dir_x_nxt = to_q14(ox);
    dir_z_nxt = to_q14(oz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= d_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dir_x_r <= dir_x_nxt;
      dir_z_r <= dir_z_nxt;
    end
  end

  assign vld   = vld_r;
  assign dir_x = dir_x_r;
  assign dir_z = dir_z_r;

endmodule

`default_nettype wire

// ===== hw/rtl/angle_to_unit_direction_core.sv =====
// angle_to_unit_direction_core: heading to (cos, sin) unit vector through
// a chain of rotation cells. Depends on cord_pkg, cord_if, cord_prep,
// cord_cell and cord_post.
//
//   channel  dir  payload                    beat
//   in_ch    in   angle   [15:0] unsigned    one heading
//   out_ch   out  dir_x, dir_z [15:0] signed one Q1.14 vector
//
// one beat accepted per cycle while out_ch does not stall; a beat passes the
//   register of each rotation cell in turn and then the output register
// a stall on out_ch freezes the whole chain; in_ch.ready drops only while
//   the output register holds a beat that is not taken
// synchronous active-low reset clears the valid bits; no clearing pass
`default_nettype none

module angle_to_unit_direction_core (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cord_in_if.sink     in_ch,
  cord_out_if.source  out_ch
);

  cord_pkg::stage_t              chain [cord_pkg::NUM_CELLS+1];
  logic [cord_pkg::NUM_CELLS:0]  vld_vec;
  logic                          out_vld;
  logic                          en;

  assign en          = !out_vld || out_ch.ready;
  assign in_ch.ready = en;

  cord_prep u_prep (
    .vld   (in_ch.valid),
    .angle (in_ch.angle),
    .d_o   (chain[0])
  );

  for (genvar g = 0; g < cord_pkg::NUM_CELLS; g++) begin : g_cell
    cord_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .sh    (cord_pkg::SH_W'(g)),
      .atan  (cord_pkg::atan_turn(cord_pkg::SH_W'(g))),
      .d_i   (chain[g]),
      .d_o   (chain[g+1])
    );
  end

  for (genvar v = 0; v <= cord_pkg::NUM_CELLS; v++) begin : g_vld
    assign vld_vec[v] = chain[v].vld;
  end

  cord_post u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .d_i   (chain[cord_pkg::NUM_CELLS]),
    .vld   (out_vld),
    .dir_x (out_ch.dir_x),
    .dir_z (out_ch.dir_z)
  );

  assign out_ch.valid = out_vld;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid right after reset");

  a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.dir_x <= 16'sd16384) && (out_ch.dir_x >= -16'sd16384))
    else $error("dir_x out of range");

  a_unit_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      ((out_ch.dir_x[15] ? -out_ch.dir_x : out_ch.dir_x) +
       (out_ch.dir_z[15] ? -out_ch.dir_z : out_ch.dir_z)) >= 16'sd16300)
    else $error("direction vector far from unit length");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(vld_vec[cord_pkg::NUM_CELLS:1]))
    else $error("cell chain moved during a stall");

endmodule

`default_nettype wire
